FILE: hw/rtl/fdtp_pkg.sv
// Shared types and constants for the devicetree structure-block parser.
// Holds token codes, event codes, the parse phase type and the event word.
// No dependencies.
package fdtp_pkg;

    localparam logic [31:0] FDT_MAGIC       = 32'hD00D_FEED;
    localparam logic [31:0] TOK_BEGIN_NODE  = 32'd1;
    localparam logic [31:0] TOK_END_NODE    = 32'd2;
    localparam logic [31:0] TOK_PROP        = 32'd3;
    localparam logic [31:0] TOK_NOP         = 32'd4;
    localparam logic [31:0] TOK_END         = 32'd9;

    localparam logic [31:0] WORD_BYTES      = 32'd4;
    localparam logic [31:0] HDR_TOTAL_POS   = 32'd4;
    localparam logic [31:0] HDR_STRUCT_POS  = 32'd8;
    localparam logic [31:0] STRUCT_MIN      = 32'd16;

    localparam int unsigned VWL_W = 30;

    typedef enum logic [1:0] {
        EV_PROP    = 2'd0,
        EV_BADHDR  = 2'd1,
        EV_END     = 2'd2,
        EV_UNKNOWN = 2'd3
    } evt_code_t;

    typedef enum logic [8:0] {
        PH_IDLE  = 9'b0_0000_0001,
        PH_HDR   = 9'b0_0000_0010,
        PH_SKIP  = 9'b0_0000_0100,
        PH_TOKEN = 9'b0_0000_1000,
        PH_NAME  = 9'b0_0001_0000,
        PH_PLEN  = 9'b0_0010_0000,
        PH_PNAME = 9'b0_0100_0000,
        PH_PVAL  = 9'b0_1000_0000,
        PH_DONE  = 9'b1_0000_0000
    } phase_t;

    typedef struct packed {
        evt_code_t   code;
        logic [31:0] name_offset;
        logic [31:0] value_offset;
        logic [31:0] value_length;
        logic [31:0] node_name_offset;
        logic [31:0] blob_size;
    } evt_t;

endpackage

FILE: hw/rtl/fdtp_in_reg.sv
// Input word register of the devicetree parser.
// Depends on fdtp_pkg only for house consistency; holds one word and its first flag.
module fdtp_in_reg (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [31:0] s_word,
    input  logic        s_first,
    input  logic        advance,
    output logic        in_valid,
    output logic [31:0] in_word,
    output logic        in_first
);
    import fdtp_pkg::*;

    logic        valid_reg, valid_next;
    logic [31:0] word_reg;
    logic        first_reg;

    assign s_ready = !valid_reg || advance;

    always_comb begin
        valid_next = valid_reg;
        if (s_ready) begin
            valid_next = s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            word_reg  <= s_word;
            first_reg <= s_first;
        end
    end

    assign in_valid = valid_reg;
    assign in_word  = word_reg;
    assign in_first = first_reg;

endmodule

FILE: hw/rtl/fdtp_decode.sv
// Parse state and per-word decode of the devicetree header and structure block.
// Depends on fdtp_pkg for token codes, phases and the event word.
module fdtp_decode (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic [31:0]   in_word,
    input  logic          in_first,
    input  logic          fire,
    output logic          evt_valid,
    output fdtp_pkg::evt_t evt
);
    import fdtp_pkg::*;

    phase_t             phase_reg, phase_next;
    logic [31:0]        byte_pos_reg, byte_pos_next;
    logic [31:0]        total_size_reg, total_size_next;
    logic [31:0]        struct_offset_reg, struct_offset_next;
    logic [31:0]        strings_offset_reg, strings_offset_next;
    logic [31:0]        prop_length_reg, prop_length_next;
    logic [VWL_W-1:0]   vwl_reg, vwl_next;
    logic [31:0]        node_start_reg, node_start_next;

    logic [31:0]        pos_plus4;
    logic               tok_go;
    logic               has_zero;
    logic [VWL_W-1:0]   len_words;
    logic               len_part;

    assign pos_plus4 = byte_pos_reg + WORD_BYTES;
    assign has_zero  = (in_word[31:24] == 8'd0) || (in_word[23:16] == 8'd0) ||
                       (in_word[15:8] == 8'd0) || (in_word[7:0] == 8'd0);
    assign len_words = prop_length_reg[31:2];
    assign len_part  = |prop_length_reg[1:0];

    always_comb begin
        phase_next          = phase_reg;
        byte_pos_next       = byte_pos_reg;
        total_size_next     = total_size_reg;
        struct_offset_next  = struct_offset_reg;
        strings_offset_next = strings_offset_reg;
        prop_length_next    = prop_length_reg;
        vwl_next            = vwl_reg;
        node_start_next     = node_start_reg;
        evt_valid           = 1'b0;
        evt                 = '{code: EV_PROP, name_offset: 32'd0, value_offset: 32'd0,
                                value_length: 32'd0, node_name_offset: 32'd0,
                                blob_size: total_size_reg};
        tok_go              = 1'b0;

        if (in_first) begin
            byte_pos_next       = WORD_BYTES;
            total_size_next     = 32'd0;
            struct_offset_next  = 32'd0;
            strings_offset_next = 32'd0;
            prop_length_next    = 32'd0;
            vwl_next            = '0;
            node_start_next     = 32'd0;
            evt.blob_size       = 32'd0;
            if (in_word == FDT_MAGIC) begin
                phase_next = PH_HDR;
            end else begin
                phase_next = PH_DONE;
                evt_valid  = 1'b1;
                evt.code   = EV_BADHDR;
            end
        end else begin
            byte_pos_next = pos_plus4;
            unique case (phase_reg)
                PH_HDR: begin
                    if (byte_pos_reg == HDR_TOTAL_POS) begin
                        total_size_next = in_word;
                    end else if (byte_pos_reg == HDR_STRUCT_POS) begin
                        struct_offset_next = in_word;
                        if ((in_word < STRUCT_MIN) || (in_word[1:0] != 2'd0)) begin
                            phase_next = PH_DONE;
                            evt_valid  = 1'b1;
                            evt.code   = EV_BADHDR;
                        end
                    end else begin
                        strings_offset_next = in_word;
                        phase_next          = PH_SKIP;
                    end
                end
                PH_SKIP: begin
                    tok_go = (byte_pos_reg == struct_offset_reg);
                end
                PH_TOKEN: begin
                    tok_go = 1'b1;
                end
                PH_NAME: begin
                    if (has_zero) begin
                        phase_next = PH_TOKEN;
                    end
                end
                PH_PLEN: begin
                    prop_length_next = in_word;
                    phase_next       = PH_PNAME;
                end
                PH_PNAME: begin
                    evt_valid            = 1'b1;
                    evt.code             = EV_PROP;
                    evt.name_offset      = strings_offset_reg + in_word;
                    evt.value_offset     = pos_plus4;
                    evt.value_length     = prop_length_reg;
                    evt.node_name_offset = node_start_reg;
                    if (prop_length_reg == 32'd0) begin
                        vwl_next   = '0;
                        phase_next = PH_TOKEN;
                    end else begin
                        vwl_next   = len_part ? len_words : len_words - 1'b1;
                        phase_next = PH_PVAL;
                    end
                end
                PH_PVAL: begin
                    if (vwl_reg == '0) begin
                        phase_next = PH_TOKEN;
                    end else begin
                        vwl_next = vwl_reg - 1'b1;
                    end
                end
                default: begin
                end
            endcase

            if (tok_go) begin
                unique case (in_word)
                    TOK_BEGIN_NODE: begin
                        node_start_next = pos_plus4;
                        phase_next      = PH_NAME;
                    end
                    TOK_PROP: begin
                        phase_next = PH_PLEN;
                    end
                    TOK_END_NODE, TOK_NOP: begin
                        phase_next = PH_TOKEN;
                    end
                    TOK_END: begin
                        phase_next = PH_DONE;
                        evt_valid  = 1'b1;
                        evt.code   = EV_END;
                    end
                    default: begin
                        phase_next = PH_TOKEN;
                        evt_valid  = 1'b1;
                        evt.code   = EV_UNKNOWN;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg          <= PH_IDLE;
            byte_pos_reg       <= 32'd0;
            total_size_reg     <= 32'd0;
            struct_offset_reg  <= 32'd0;
            strings_offset_reg <= 32'd0;
            prop_length_reg    <= 32'd0;
            vwl_reg            <= '0;
            node_start_reg     <= 32'd0;
        end else if (fire) begin
            phase_reg          <= phase_next;
            byte_pos_reg       <= byte_pos_next;
            total_size_reg     <= total_size_next;
            struct_offset_reg  <= struct_offset_next;
            strings_offset_reg <= strings_offset_next;
            prop_length_reg    <= prop_length_next;
            vwl_reg            <= vwl_next;
            node_start_reg     <= node_start_next;
        end
    end

endmodule

FILE: hw/rtl/fdtp_out_reg.sv
// Result register of the devicetree parser.
// Depends on fdtp_pkg for the event word; holds one event until taken.
module fdtp_out_reg (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           load,
    input  fdtp_pkg::evt_t evt,
    output logic           free,
    output logic           m_valid,
    input  logic           m_ready,
    output fdtp_pkg::evt_t evt_out
);
    import fdtp_pkg::*;

    logic valid_reg, valid_next;
    evt_t evt_reg;

    assign free = !valid_reg || m_ready;

    always_comb begin
        valid_next = valid_reg;
        if (load) begin
            valid_next = 1'b1;
        end else if (m_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            evt_reg <= evt;
        end
    end

    assign m_valid = valid_reg;
    assign evt_out = evt_reg;

endmodule

FILE: hw/rtl/fdt_structure_token_parser.sv
// Devicetree blob parser: header check, skip to structure block, token decode.
// One word per cycle sustained while the result register can take each event.
// Throughput is set by the single decode stage between input and result registers.
// Reset: aresetn synchronous, active low; clears handshakes and parse state to idle.
// Depends on fdtp_pkg, fdtp_in_reg, fdtp_decode, fdtp_out_reg.
module fdt_structure_token_parser (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [31:0] s_word,
    input  logic        s_first,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_event_res,
    output logic [31:0] m_name_offset,
    output logic [31:0] m_value_offset,
    output logic [31:0] m_value_length,
    output logic [31:0] m_node_name_offset,
    output logic [31:0] m_blob_size
);
    import fdtp_pkg::*;

    logic        in_valid;
    logic [31:0] in_word;
    logic        in_first;
    logic        advance;
    logic        evt_valid;
    logic        out_free;
    logic        load;
    evt_t        evt;
    evt_t        evt_out;

    assign advance = in_valid && (!evt_valid || out_free);
    assign load    = advance && evt_valid;

    fdtp_in_reg u_in (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_word   (s_word),
        .s_first  (s_first),
        .advance  (advance),
        .in_valid (in_valid),
        .in_word  (in_word),
        .in_first (in_first)
    );

    fdtp_decode u_dec (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_word   (in_word),
        .in_first  (in_first),
        .fire      (advance),
        .evt_valid (evt_valid),
        .evt       (evt)
    );

    fdtp_out_reg u_out (
        .aclk    (aclk),
        .aresetn (aresetn),
        .load    (load),
        .evt     (evt),
        .free    (out_free),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .evt_out (evt_out)
    );

    assign m_event_res        = evt_out.code;
    assign m_name_offset      = evt_out.name_offset;
    assign m_value_offset     = evt_out.value_offset;
    assign m_value_length     = evt_out.value_length;
    assign m_node_name_offset = evt_out.node_name_offset;
    assign m_blob_size        = evt_out.blob_size;

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        load |-> (!m_valid || m_ready))
        else $error("result register loaded while holding an untaken event");

    a_bad_magic: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && in_first && (in_word != FDT_MAGIC))
            |=> (m_valid && (m_event_res == EV_BADHDR) && (m_blob_size == 32'd0)))
        else $error("bad magic did not yield a bad header event");

    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> (!m_valid && s_ready))
        else $error("handshakes not idle after reset");

endmodule

FILE: tb/sv/fdt_event_checker.sv
`timescale 1ns / 100ps
// Event checker for fdt_structure_token_parser: watches the word and event channels,
// predicts parser events and compares them field by field. Depends on fdtp_pkg.
module fdt_event_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    input  logic        s_ready,
    input  logic [31:0] s_word,
    input  logic        s_first,
    input  logic        m_valid,
    input  logic        m_ready,
    input  logic [1:0]  m_event_res,
    input  logic [31:0] m_name_offset,
    input  logic [31:0] m_value_offset,
    input  logic [31:0] m_value_length,
    input  logic [31:0] m_node_name_offset,
    input  logic [31:0] m_blob_size,
    output int          mismatches,
    output int          pending_events,
    output int          props_seen,
    output int          bad_headers_seen,
    output int          ends_seen,
    output int          unknowns_seen
);
    import fdtp_pkg::*;

    phase_t           parse_phase;
    logic [31:0]      cursor;
    logic [31:0]      blob_total;
    logic [31:0]      struct_base;
    logic [31:0]      strings_base;
    logic [31:0]      prop_len;
    logic [VWL_W-1:0] value_words_rem;
    logic [31:0]      node_start;

    evt_t expected_events[$];
    int   miss_count;
    int   event_tally [4];

    initial begin
        miss_count = 0;
        foreach (event_tally[i]) event_tally[i] = 0;
    end

    function automatic void clear_state();
        parse_phase = PH_IDLE;
        cursor = '0;
        blob_total = '0;
        struct_base = '0;
        strings_base = '0;
        prop_len = '0;
        value_words_rem = '0;
        node_start = '0;
    endfunction

    function automatic bit take_token(input logic [31:0] tok, input logic [31:0] pos,
                                      output evt_t ev);
        ev = '0;
        ev.blob_size = blob_total;
        case (tok)
            TOK_BEGIN_NODE: begin
                node_start = pos + WORD_BYTES;
                parse_phase = PH_NAME;
            end
            TOK_PROP: parse_phase = PH_PLEN;
            TOK_END_NODE, TOK_NOP: parse_phase = PH_TOKEN;
            TOK_END: begin
                parse_phase = PH_DONE;
                ev.code = EV_END;
                return 1'b1;
            end
            default: begin
                parse_phase = PH_TOKEN;
                ev.code = EV_UNKNOWN;
                return 1'b1;
            end
        endcase
        return 1'b0;
    endfunction

    // Advance the parse by one word; return 1 when the word yields an event.
    function automatic bit parse_word(input logic [31:0] w, input logic f, output evt_t ev);
        logic [31:0] pos;
        logic [31:0] n_words;
        ev = '0;
        if (f) begin
            clear_state();
            cursor = WORD_BYTES;
            if (w != FDT_MAGIC) begin
                parse_phase = PH_DONE;
                ev.code = EV_BADHDR;
                return 1'b1;
            end
            parse_phase = PH_HDR;
            return 1'b0;
        end
        pos = cursor;
        cursor = pos + WORD_BYTES;
        ev.blob_size = blob_total;
        case (parse_phase)
            PH_HDR: begin
                if (pos == HDR_TOTAL_POS) begin
                    blob_total = w;
                end else if (pos == HDR_STRUCT_POS) begin
                    struct_base = w;
                    if (w < STRUCT_MIN || w[1:0] != 2'b00) begin
                        parse_phase = PH_DONE;
                        ev.code = EV_BADHDR;
                        return 1'b1;
                    end
                end else begin
                    strings_base = w;
                    parse_phase = PH_SKIP;
                end
            end
            PH_SKIP: begin
                if (pos == struct_base) return take_token(w, pos, ev);
            end
            PH_TOKEN: return take_token(w, pos, ev);
            PH_NAME: begin
                if (w[31:24] == 8'h00 || w[23:16] == 8'h00 ||
                    w[15:8] == 8'h00 || w[7:0] == 8'h00) parse_phase = PH_TOKEN;
            end
            PH_PLEN: begin
                prop_len = w;
                parse_phase = PH_PNAME;
            end
            PH_PNAME: begin
                n_words = (prop_len >> 2) + ((prop_len[1:0] != 2'b00) ? 32'd1 : 32'd0);
                ev.code = EV_PROP;
                ev.name_offset = strings_base + w;
                ev.value_offset = pos + WORD_BYTES;
                ev.value_length = prop_len;
                ev.node_name_offset = node_start;
                if (n_words == 0) begin
                    value_words_rem = '0;
                    parse_phase = PH_TOKEN;
                end else begin
                    value_words_rem = VWL_W'(n_words - 1);
                    parse_phase = PH_PVAL;
                end
                return 1'b1;
            end
            PH_PVAL: begin
                if (value_words_rem == 0) parse_phase = PH_TOKEN;
                else value_words_rem = value_words_rem - 1'b1;
            end
            default: ;
        endcase
        return 1'b0;
    endfunction

    task automatic check_field(input string label, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %h, got %h", $time, label, want, got);
            miss_count++;
        end
    endtask

    always @(posedge aclk) begin
        evt_t fresh;
        evt_t want;
        bit   hit;
        if (!aresetn) begin
            clear_state();
            expected_events.delete();
        end else begin
            if (s_valid && s_ready) begin
                hit = parse_word(s_word, s_first, fresh);
                if (hit) expected_events.push_back(fresh);
            end
            if (m_valid && m_ready) begin
                if (expected_events.size() == 0) begin
                    $display("%0t: unexpected event, expected none, got code %0d",
                             $time, m_event_res);
                    miss_count++;
                end else begin
                    want = expected_events.pop_front();
                    check_field("event_res", 32'(want.code), 32'(m_event_res));
                    check_field("name_offset", want.name_offset, m_name_offset);
                    check_field("value_offset", want.value_offset, m_value_offset);
                    check_field("value_length", want.value_length, m_value_length);
                    check_field("node_name_offset", want.node_name_offset,
                                m_node_name_offset);
                    check_field("blob_size", want.blob_size, m_blob_size);
                    event_tally[want.code]++;
                end
            end
        end
        pending_events <= expected_events.size();
        mismatches <= miss_count;
        props_seen <= event_tally[EV_PROP];
        bad_headers_seen <= event_tally[EV_BADHDR];
        ends_seen <= event_tally[EV_END];
        unknowns_seen <= event_tally[EV_UNKNOWN];
    end

endmodule

FILE: tb/sv/tb.sv
`timescale 1ns / 100ps
// Top of the fdt_structure_token_parser testbench: clock, reset, blob word stimulus
// and the verdict. Depends on fdtp_pkg, fdt_event_checker and the parser RTL.
module tb;
    import fdtp_pkg::*;

    localparam int CYCLE_LIMIT = 400000;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [31:0] s_word = '0;
    logic        s_first = 1'b0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [1:0]  m_event_res;
    logic [31:0] m_name_offset;
    logic [31:0] m_value_offset;
    logic [31:0] m_value_length;
    logic [31:0] m_node_name_offset;
    logic [31:0] m_blob_size;

    int mismatches;
    int pending_events;
    int props_seen;
    int bad_headers_seen;
    int ends_seen;
    int unknowns_seen;

    int send_gap = 32;
    int recv_gap = 78;
    int words_sent = 0;
    int cycles = 0;

    fdt_structure_token_parser dut (.*);
    fdt_event_checker          chk (.*);

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    always @(negedge aclk) m_ready <= ($urandom_range(0, 99) >= recv_gap);

    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    task automatic put_word(input logic [31:0] w, input logic f);
        while ($urandom_range(0, 99) < send_gap) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_word <= w;
        s_first <= f;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        words_sent++;
        @(negedge aclk);
    endtask

    // Hold the sender until every expected event has come back.
    task automatic drain();
        s_valid <= 1'b0;
        do @(negedge aclk); while (pending_events != 0);
    endtask

    function automatic logic [31:0] name_body();
        return {8'($urandom_range(1, 255)), 8'($urandom_range(1, 255)),
                8'($urandom_range(1, 255)), 8'($urandom_range(1, 255))};
    endfunction

    function automatic logic [31:0] name_tail();
        logic [31:0] w;
        int          k;
        w = $urandom;
        k = $urandom_range(0, 3);
        w[k*8 +: 8] = 8'h00;
        return w;
    endfunction

    task automatic send_header(input logic [31:0] total, input logic [31:0] sofs);
        put_word(FDT_MAGIC, 1'b1);
        put_word(total, 1'b0);
        put_word(sofs, 1'b0);
    endtask

    task automatic send_node(input int n_words);
        put_word(TOK_BEGIN_NODE, 1'b0);
        for (int i = 1; i < n_words; i++) put_word(name_body(), 1'b0);
        put_word(name_tail(), 1'b0);
    endtask

    // Send at most 16 value words; longer values are cut off by the next blob.
    task automatic send_prop(input logic [31:0] len, input logic [31:0] noff);
        logic [31:0] n_words;
        n_words = (len >> 2) + ((len[1:0] != 2'b00) ? 32'd1 : 32'd0);
        put_word(TOK_PROP, 1'b0);
        put_word(len, 1'b0);
        put_word(noff, 1'b0);
        for (int i = 0; i < n_words && i < 16; i++) put_word($urandom, 1'b0);
    endtask

    task automatic random_blob();
        logic [31:0] sofs;
        logic [31:0] len;
        logic [31:0] tok;
        int          r;
        bit          cut;
        r = $urandom_range(0, 99);
        if (r < 5) begin
            put_word($urandom, 1'b1);
            repeat ($urandom_range(0, 3)) put_word($urandom, 1'b0);
            return;
        end
        if (r < 12) begin
            sofs = ($urandom_range(0, 1) == 0) ? 32'($urandom_range(0, 15))
                                               : (32'($urandom_range(16, 60)) | 32'd1);
            send_header($urandom, sofs);
            repeat ($urandom_range(0, 2)) put_word($urandom, 1'b0);
            return;
        end
        sofs = STRUCT_MIN + WORD_BYTES * $urandom_range(0, 3);
        send_header($urandom, sofs);
        put_word($urandom, 1'b0);
        for (int i = 16; i < sofs; i += 4) put_word($urandom, 1'b0);
        cut = 1'b0;
        repeat ($urandom_range(1, 12)) begin
            r = $urandom_range(0, 99);
            if (r < 30) begin
                send_node($urandom_range(1, 3));
            end else if (r < 65) begin
                len = ($urandom_range(0, 99) < 92) ? 32'($urandom_range(0, 24)) : $urandom;
                send_prop(len, $urandom);
                if (len > 64) begin
                    cut = 1'b1;
                    break;
                end
            end else if (r < 75) begin
                put_word(TOK_NOP, 1'b0);
            end else if (r < 85) begin
                put_word(TOK_END_NODE, 1'b0);
            end else begin
                case ($urandom_range(0, 2))
                    0:       tok = 32'd0;
                    1:       tok = $urandom_range(5, 8);
                    default: tok = $urandom_range(10, 32'hFFFF_FFFF);
                endcase
                put_word(tok, 1'b0);
            end
        end
        if (!cut && $urandom_range(0, 99) < 85) begin
            put_word(TOK_END, 1'b0);
            repeat ($urandom_range(0, 2)) put_word($urandom, 1'b0);
        end
    endtask

    task automatic run_blobs(input int target);
        while (words_sent < target) random_blob();
    endtask

    initial begin
        repeat (7) @(negedge aclk);
        aresetn <= 1'b1;

        put_word(32'hFFFF_FFFF, 1'b0);
        put_word(32'h0000_0000, 1'b1);
        put_word(TOK_PROP, 1'b0);
        send_header(32'hFFFF_FFFF, 32'd12);
        send_header(32'd0, 32'h11);
        send_header(32'h100, STRUCT_MIN);
        put_word(32'hFFFF_FFF0, 1'b0);
        send_prop(32'd0, 32'h20);
        send_node(1);
        put_word(TOK_NOP, 1'b0);
        put_word(TOK_END_NODE, 1'b0);
        put_word(32'hFFFF_FFFF, 1'b0);
        send_prop(32'd4, 32'd0);
        put_word(TOK_END, 1'b0);
        put_word(TOK_PROP, 1'b0);

        run_blobs(350);
        drain();
        send_gap = 78;
        recv_gap = 32;
        run_blobs(700);
        drain();
        send_gap = 0;
        recv_gap = 0;
        run_blobs(1050);
        drain();
        repeat (8) @(negedge aclk);

        $display("Sent %0d blob words across three idle profiles.", words_sent);
        $display("Checked %0d property, %0d bad-header, %0d end and %0d unknown-token events.",
                 props_seen, bad_headers_seen, ends_seen, unknowns_seen);
        if (mismatches == 0 && pending_events == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

FILE: filelist.f
hw/rtl/fdtp_pkg.sv
hw/rtl/fdtp_in_reg.sv
hw/rtl/fdtp_decode.sv
hw/rtl/fdtp_out_reg.sv
hw/rtl/fdt_structure_token_parser.sv
tb/sv/fdt_event_checker.sv
tb/sv/tb.sv
